// ===== rtl/csvp_pkg.sv =====
// ----------------------------------------------------------------------------
// csvp_pkg: shared types and constants for the CSV field parser
// Character codes, parser mode encoding and the result word layout.
// ----------------------------------------------------------------------------
package csvp_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Parser mode. Codes six and seven are never reached; they decode as
    // cell start.
    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_PLAIN  = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_QSEEN  = 3'd3,
        MODE_SKIP   = 3'd4,
        MODE_ERROR  = 3'd5
    } mode_t;

    // One result word.
    typedef struct packed {
        logic [7:0] content_byte;
        logic       content_valid;
        logic       cell_done;
        logic       cell_null;
        logic       row_first;
        logic       table_done;
        logic       bad_format;
    } result_t;

    function automatic logic is_delim(input logic [7:0] b);
        return (b == CH_COMMA) || (b == CH_CR) || (b == CH_LF);
    endfunction

endpackage

// ===== rtl/csvp_fsm.sv =====
// ----------------------------------------------------------------------------
// csvp_fsm: CSV tokenizer state machine
// Holds parser mode, row-start and cell-text flags; decides one byte per
// enabled cycle and produces the result word combinationally.
// ----------------------------------------------------------------------------
module csvp_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    input  logic              at_end,
    output csvp_pkg::result_t result
);

    csvp_pkg::mode_t mode_reg, mode_next;
    logic            row_start_reg, row_start_next;
    logic            has_text_reg, has_text_next;

    logic is_quote;
    logic is_dl;

    assign is_quote = (data_byte == csvp_pkg::CH_QUOTE);
    assign is_dl    = csvp_pkg::is_delim(data_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= csvp_pkg::MODE_START;
            row_start_reg <= 1'b1;
            has_text_reg  <= 1'b0;
        end else if (step_en) begin
            mode_reg      <= mode_next;
            row_start_reg <= row_start_next;
            has_text_reg  <= has_text_next;
        end
    end

    // Next state
    always_comb begin
        mode_next      = mode_reg;
        row_start_next = row_start_reg;
        has_text_next  = has_text_reg;
        if (at_end) begin
            if (mode_reg == csvp_pkg::MODE_QUOTED) begin
                mode_next = csvp_pkg::MODE_ERROR;
            end else begin
                // table end or error recovery: back to reset state
                mode_next      = csvp_pkg::MODE_START;
                row_start_next = 1'b1;
                has_text_next  = 1'b0;
            end
        end else begin
            case (mode_reg)
                csvp_pkg::MODE_PLAIN: begin
                    if (is_dl) begin
                        mode_next      = (data_byte == csvp_pkg::CH_CR) ?
                                         csvp_pkg::MODE_SKIP : csvp_pkg::MODE_START;
                        row_start_next = (data_byte != csvp_pkg::CH_COMMA);
                        has_text_next  = 1'b0;
                    end else begin
                        has_text_next = 1'b1;
                    end
                end
                csvp_pkg::MODE_QUOTED: begin
                    if (is_quote) begin
                        mode_next = csvp_pkg::MODE_QSEEN;
                    end else begin
                        has_text_next = 1'b1;
                    end
                end
                csvp_pkg::MODE_QSEEN: begin
                    if (is_quote) begin
                        mode_next     = csvp_pkg::MODE_QUOTED;
                        has_text_next = 1'b1;
                    end else if (is_dl) begin
                        mode_next      = (data_byte == csvp_pkg::CH_CR) ?
                                         csvp_pkg::MODE_SKIP : csvp_pkg::MODE_START;
                        row_start_next = (data_byte != csvp_pkg::CH_COMMA);
                        has_text_next  = 1'b0;
                    end else begin
                        mode_next = csvp_pkg::MODE_ERROR;
                    end
                end
                csvp_pkg::MODE_SKIP: begin
                    mode_next = csvp_pkg::MODE_START;
                end
                csvp_pkg::MODE_ERROR: begin
                    mode_next = csvp_pkg::MODE_ERROR;
                end
                default: begin
                    // cell start (unused codes decode here too)
                    if (is_quote) begin
                        mode_next = csvp_pkg::MODE_QUOTED;
                    end else if (is_dl) begin
                        mode_next      = (data_byte == csvp_pkg::CH_CR) ?
                                         csvp_pkg::MODE_SKIP : csvp_pkg::MODE_START;
                        row_start_next = (data_byte != csvp_pkg::CH_COMMA);
                        has_text_next  = 1'b0;
                    end else begin
                        mode_next     = csvp_pkg::MODE_PLAIN;
                        has_text_next = 1'b1;
                    end
                end
            endcase
        end
    end

    // Outputs
    always_comb begin
        result = '0;
        if (at_end) begin
            case (mode_reg)
                csvp_pkg::MODE_ERROR: begin
                    result = '0;
                end
                csvp_pkg::MODE_QUOTED: begin
                    result.bad_format = 1'b1;
                end
                csvp_pkg::MODE_PLAIN, csvp_pkg::MODE_QSEEN: begin
                    result.cell_done  = 1'b1;
                    result.cell_null  = ~has_text_reg;
                    result.row_first  = row_start_reg;
                    result.table_done = 1'b1;
                end
                default: begin
                    result.table_done = 1'b1;
                end
            endcase
        end else begin
            case (mode_reg)
                csvp_pkg::MODE_PLAIN: begin
                    if (is_dl) begin
                        result.cell_done = 1'b1;
                        result.cell_null = ~has_text_reg;
                        result.row_first = row_start_reg;
                    end else begin
                        result.content_byte  = data_byte;
                        result.content_valid = 1'b1;
                    end
                end
                csvp_pkg::MODE_QUOTED: begin
                    if (!is_quote) begin
                        result.content_byte  = data_byte;
                        result.content_valid = 1'b1;
                    end
                end
                csvp_pkg::MODE_QSEEN: begin
                    if (is_quote) begin
                        result.content_byte  = csvp_pkg::CH_QUOTE;
                        result.content_valid = 1'b1;
                    end else if (is_dl) begin
                        result.cell_done = 1'b1;
                        result.cell_null = ~has_text_reg;
                        result.row_first = row_start_reg;
                    end else begin
                        result.bad_format = 1'b1;
                    end
                end
                csvp_pkg::MODE_SKIP, csvp_pkg::MODE_ERROR: begin
                    result = '0;
                end
                default: begin
                    if (is_quote) begin
                        result = '0;
                    end else if (is_dl) begin
                        result.cell_done = 1'b1;
                        result.cell_null = ~has_text_reg;
                        result.row_first = row_start_reg;
                    end else begin
                        result.content_byte  = data_byte;
                        result.content_valid = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/csv_field_parser_top.sv =====
// ----------------------------------------------------------------------------
// csv_field_parser_top: streaming CSV cell tokenizer, one result word per byte
// Path: an accepted word is held in the input register, its result in the result register.
// Throughput: 1 word per cycle while m_ready is high; the parser state loop holds no extra register.
// Reset: synchronous active-low aresetn empties both stages, parser at cell start.
// ----------------------------------------------------------------------------
module csv_field_parser_top (
    input  logic       aclk,
    input  logic       aresetn,

    // input word channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_at_end,

    // result word channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_content_byte,
    output logic       m_content_valid,
    output logic       m_cell_done,
    output logic       m_cell_null,
    output logic       m_row_first,
    output logic       m_table_done,
    output logic       m_bad_format
);

    // Stage 1: input register. Holds one accepted word until the parser
    // consumes it.
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // Stage 2: result register.
    logic              out_vld_reg;
    csvp_pkg::result_t out_reg;

    csvp_pkg::result_t step_result;
    logic              step_en;

    // The parser steps when a word waits in stage 1 and the result register
    // is empty or being drained this cycle. The state update and the result
    // load happen on the same edge.
    assign step_en = in_vld_reg && (!out_vld_reg || m_ready);

    // Stage 1 may take a new word whenever it is empty or its word moves on.
    assign s_ready = !in_vld_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_at_end;
        end
    end

    // Parser: mode / row-start / cell-text state plus the per-byte decision.
    csvp_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .data_byte (in_byte_reg),
        .at_end    (in_end_reg),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step_en) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_reg <= step_result;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_content_byte  = out_reg.content_byte;
    assign m_content_valid = out_reg.content_valid;
    assign m_cell_done     = out_reg.cell_done;
    assign m_cell_null     = out_reg.cell_null;
    assign m_row_first     = out_reg.row_first;
    assign m_table_done    = out_reg.table_done;
    assign m_bad_format    = out_reg.bad_format;

endmodule
